// File: rtl/tep_pkg.sv
// shared types, constants and register codes of the thermal erosion pass
package tep_pkg;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int MAX_ROWS_DEF  = 4096;

    localparam int HGT_W    = 24;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 12;
    localparam int GW_W     = 9;
    localparam int GH_W     = 13;
    localparam int TALUS_W  = 23;
    localparam int RATE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    localparam logic [RATE_W-1:0] RATE_MAX = 16'd32768;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TALUS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLIDE_RATE  = 3'd3;

    // front-to-back queue and output queue
    localparam int Q_DEPTH = 4;
    localparam int QCW     = $clog2(Q_DEPTH + 1);
    localparam int O_DEPTH = 8;
    localparam int OCW     = $clog2(O_DEPTH + 1);

    typedef logic signed [HGT_W-1:0] height_t;

    typedef struct packed {
        logic [GW_W-1:0] grid_width;
        logic [GH_W-1:0] grid_height;
        logic            restart;
    } geom_t;

    typedef struct packed {
        logic [TALUS_W-1:0] talus;
        logic [RATE_W-1:0]  rate;
    } erode_cfg_t;

    typedef struct packed {
        height_t          here;
        height_t          left;
        height_t          right;
        height_t          up;
        height_t          down;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             eof;
    } job_t;

    typedef struct packed {
        logic [2:0]     valid;
        job_t [2:0]     job;
    } bundle_t;

    typedef struct packed {
        height_t          new_height;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
        logic             eof;
    } result_t;

endpackage

// File: rtl/tep_front.sv
// front end: position counters, line stores and stencil jobs per sample
module tep_front #(
    parameter int MAX_WIDTH = tep_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = tep_pkg::MAX_ROWS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  tep_pkg::geom_t           geom,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  tep_pkg::height_t         height_in,
    input  logic [tep_pkg::QCW-1:0]  q_count,
    output logic                     push,
    output tep_pkg::bundle_t         bundle
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_ROWS);

    logic [CW:0]   w_eff;
    logic [RW:0]   h_eff;
    logic [CW-1:0] c_reg, c_next, c_cur, a_rt, a_lt;
    logic [RW-1:0] r_reg, r_next, r_cur;
    logic          c_end, r_end, accept;

    tep_pkg::height_t recent_mem [MAX_WIDTH];
    tep_pkg::height_t older_mem  [MAX_WIDTH];

    logic             s1_valid_reg;
    tep_pkg::height_t x_reg, prev_reg, prev2_reg;
    tep_pkg::height_t x_s1_reg, prev_s1_reg, prev2_s1_reg;
    tep_pkg::height_t here_s1_reg, rt_s1_reg, up_s1_reg, upl_s1_reg;
    logic [CW-1:0]    c_s1_reg;
    logic [RW-1:0]    r_s1_reg;
    logic             r_gt0_reg, r_ge2_reg, last_row_reg;
    logic             c_gt0_reg, c_ge2_reg, c_last_reg, rt_ok_reg;

    tep_pkg::job_t    j0, j1, j2;
    logic [2:0]       jv;

    // clamp geometry to the supported range
    always_comb begin
        if (geom.grid_width == '0) begin
            w_eff = (CW+1)'(1);
        end else if (32'(geom.grid_width) > MAX_WIDTH) begin
            w_eff = (CW+1)'(MAX_WIDTH);
        end else begin
            w_eff = (CW+1)'(geom.grid_width);
        end
        if (geom.grid_height == '0) begin
            h_eff = (RW+1)'(1);
        end else if (32'(geom.grid_height) > MAX_ROWS) begin
            h_eff = (RW+1)'(MAX_ROWS);
        end else begin
            h_eff = (RW+1)'(geom.grid_height);
        end
    end

    assign c_cur  = ((CW+1)'(c_reg) >= w_eff) ? '0 : c_reg;
    assign r_cur  = ((RW+1)'(r_reg) >= h_eff) ? '0 : r_reg;
    assign c_end  = ((CW+1)'(c_cur) + (CW+1)'(1)) >= w_eff;
    assign r_end  = ((RW+1)'(r_cur) + (RW+1)'(1)) >= h_eff;
    assign a_rt   = c_cur + 1'b1;
    assign a_lt   = c_cur - 1'b1;

    assign s_tready = (q_count + tep_pkg::QCW'(s1_valid_reg)) < tep_pkg::QCW'(tep_pkg::Q_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        c_next = c_reg;
        r_next = r_reg;
        if (geom.restart) begin
            c_next = '0;
            r_next = '0;
        end else if (accept) begin
            if (c_end) begin
                c_next = '0;
                r_next = r_end ? '0 : r_cur + 1'b1;
            end else begin
                c_next = c_cur + 1'b1;
                r_next = r_cur;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg        <= '0;
            r_reg        <= '0;
            prev_reg     <= '0;
            prev2_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            c_reg        <= c_next;
            r_reg        <= r_next;
            s1_valid_reg <= accept;
            if (accept) begin
                prev_reg  <= height_in;
                prev2_reg <= prev_reg;
            end
        end
    end

    // line stores; older row is written in the cycle after the read of the recent row
    always_ff @(posedge aclk) begin
        if (accept) begin
            recent_mem[c_cur] <= height_in;
            here_s1_reg <= recent_mem[c_cur];
            rt_s1_reg   <= recent_mem[a_rt];
            up_s1_reg   <= (s1_valid_reg && c_s1_reg == c_cur) ? here_s1_reg
                                                               : older_mem[c_cur];
            upl_s1_reg  <= (s1_valid_reg && c_s1_reg == a_lt) ? here_s1_reg
                                                              : older_mem[a_lt];
        end
        if (s1_valid_reg) begin
            older_mem[c_s1_reg] <= here_s1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_s1_reg     <= height_in;
            prev_s1_reg  <= prev_reg;
            prev2_s1_reg <= prev2_reg;
            c_s1_reg     <= c_cur;
            r_s1_reg     <= r_cur;
            r_gt0_reg    <= r_cur != '0;
            r_ge2_reg    <= r_cur > RW'(1);
            last_row_reg <= r_end;
            c_gt0_reg    <= c_cur != '0;
            c_ge2_reg    <= c_cur > CW'(1);
            c_last_reg   <= c_end;
            rt_ok_reg    <= !c_end;
        end
    end

    always_comb begin
        jv = {last_row_reg & c_last_reg, last_row_reg & c_gt0_reg, r_gt0_reg};

        j0.here  = here_s1_reg;
        j0.left  = c_gt0_reg ? upl_s1_reg : here_s1_reg;
        j0.right = rt_ok_reg ? rt_s1_reg : here_s1_reg;
        j0.up    = r_ge2_reg ? up_s1_reg : here_s1_reg;
        j0.down  = x_s1_reg;
        j0.col   = tep_pkg::COL_W'(c_s1_reg);
        j0.row   = tep_pkg::ROW_W'(r_s1_reg - 1'b1);
        j0.last  = !jv[1] && !jv[2];
        j0.eof   = 1'b0;

        j1.here  = prev_s1_reg;
        j1.left  = c_ge2_reg ? prev2_s1_reg : prev_s1_reg;
        j1.right = x_s1_reg;
        j1.up    = r_gt0_reg ? upl_s1_reg : prev_s1_reg;
        j1.down  = prev_s1_reg;
        j1.col   = tep_pkg::COL_W'(c_s1_reg - 1'b1);
        j1.row   = tep_pkg::ROW_W'(r_s1_reg);
        j1.last  = !jv[2];
        j1.eof   = 1'b0;

        j2.here  = x_s1_reg;
        j2.left  = c_gt0_reg ? prev_s1_reg : x_s1_reg;
        j2.right = x_s1_reg;
        j2.up    = r_gt0_reg ? here_s1_reg : x_s1_reg;
        j2.down  = x_s1_reg;
        j2.col   = tep_pkg::COL_W'(c_s1_reg);
        j2.row   = tep_pkg::ROW_W'(r_s1_reg);
        j2.last  = 1'b1;
        j2.eof   = 1'b1;

        bundle.valid  = jv;
        bundle.job[0] = j0;
        bundle.job[1] = j1;
        bundle.job[2] = j2;
    end

    assign push = s1_valid_reg && (jv != '0);

endmodule

// File: rtl/tep_queue.sv
// short job queue between front end and erosion back end
module tep_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  tep_pkg::bundle_t        din,
    input  logic                    pop,
    output tep_pkg::bundle_t        dout,
    output logic                    not_empty,
    output logic [tep_pkg::QCW-1:0] count
);

    localparam int PW = $clog2(tep_pkg::Q_DEPTH);

    tep_pkg::bundle_t          entry_reg [tep_pkg::Q_DEPTH];
    logic [PW-1:0]             wr_ptr_reg, rd_ptr_reg;
    logic [tep_pkg::QCW-1:0]   count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + tep_pkg::QCW'(push) - tep_pkg::QCW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout      = entry_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

// File: rtl/tep_back.sv
// back end: job issue, erosion arithmetic pipeline and result queue
module tep_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tep_pkg::erode_cfg_t cfg,
    input  tep_pkg::bundle_t    q_dout,
    input  logic                q_valid,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output tep_pkg::result_t    m_result
);

    localparam int OPW = $clog2(tep_pkg::O_DEPTH);
    localparam logic [43:0] ROUND_HALF = 44'd131072;

    logic [2:0]        done_reg, avail, pick, remain;
    logic [1:0]        idx;
    logic              credit_ok, issue;
    tep_pkg::job_t     job;

    logic              p1_v_reg, p2_v_reg;
    logic [26:0]       loss_reg, gain_reg;
    logic [42:0]       lm_reg, gm_reg;
    tep_pkg::height_t  here1_reg, here2_reg;
    logic [tep_pkg::COL_W-1:0] col1_reg, col2_reg;
    logic [tep_pkg::ROW_W-1:0] row1_reg, row2_reg;
    logic              last1_reg, last2_reg, eof1_reg, eof2_reg;

    logic [26:0]       loss_c, gain_c;
    logic [43:0]       lsum, gsum;
    logic signed [27:0] v;
    tep_pkg::result_t  res;

    tep_pkg::result_t        ofifo_reg [tep_pkg::O_DEPTH];
    logic [OPW-1:0]          owr_reg, ord_reg;
    logic [tep_pkg::OCW-1:0] ocount_reg;
    logic                    opop;

    // excess of hi over lo beyond the talus, zero when stable
    function automatic logic [24:0] over(input tep_pkg::height_t hi,
                                         input tep_pkg::height_t lo,
                                         input logic [tep_pkg::TALUS_W-1:0] t);
        logic signed [25:0] d;
        begin
            d = 26'(hi) - 26'(lo) - $signed({3'b000, t});
            return (d > 26'sd0) ? d[24:0] : 25'd0;
        end
    endfunction

    // pick the lowest job of the head bundle not yet issued
    assign avail = q_valid ? (q_dout.valid & ~done_reg) : 3'b000;
    always_comb begin
        if (avail[0]) begin
            idx = 2'd0;
        end else if (avail[1]) begin
            idx = 2'd1;
        end else begin
            idx = 2'd2;
        end
    end
    assign pick      = 3'b001 << idx;
    assign remain    = avail & ~pick;
    assign credit_ok = (ocount_reg + tep_pkg::OCW'(p1_v_reg) + tep_pkg::OCW'(p2_v_reg))
                       < tep_pkg::OCW'(tep_pkg::O_DEPTH);
    assign issue     = credit_ok && (avail != '0);
    assign q_pop     = issue && (remain == '0);
    assign job       = q_dout.job[idx];

    always_comb begin
        loss_c = 27'(over(job.here, job.left,  cfg.talus))
               + 27'(over(job.here, job.right, cfg.talus))
               + 27'(over(job.here, job.up,    cfg.talus))
               + 27'(over(job.here, job.down,  cfg.talus));
        gain_c = 27'(over(job.left,  job.here, cfg.talus))
               + 27'(over(job.right, job.here, cfg.talus))
               + 27'(over(job.up,    job.here, cfg.talus))
               + 27'(over(job.down,  job.here, cfg.talus));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= '0;
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            if (q_pop) begin
                done_reg <= '0;
            end else if (issue) begin
                done_reg <= done_reg | pick;
            end
        end
    end

    always_ff @(posedge aclk) begin
        loss_reg  <= loss_c;
        gain_reg  <= gain_c;
        here1_reg <= job.here;
        col1_reg  <= job.col;
        row1_reg  <= job.row;
        last1_reg <= job.last;
        eof1_reg  <= job.eof;

        lm_reg    <= 43'(loss_reg) * 43'(cfg.rate);
        gm_reg    <= 43'(gain_reg) * 43'(cfg.rate);
        here2_reg <= here1_reg;
        col2_reg  <= col1_reg;
        row2_reg  <= row1_reg;
        last2_reg <= last1_reg;
        eof2_reg  <= eof1_reg;
    end

    // round half up, apply and saturate
    always_comb begin
        lsum = 44'(lm_reg) + ROUND_HALF;
        gsum = 44'(gm_reg) + ROUND_HALF;
        v = 28'(here2_reg) - $signed({2'b00, lsum[43:18]}) + $signed({2'b00, gsum[43:18]});
        if (v > 28'sd8388607) begin
            res.new_height = 24'sh7fffff;
        end else if (v < -28'sd8388608) begin
            res.new_height = 24'sh800000;
        end else begin
            res.new_height = v[23:0];
        end
        res.col  = col2_reg;
        res.row  = row2_reg;
        res.last = last2_reg;
        res.eof  = eof2_reg;
    end

    assign opop = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owr_reg    <= '0;
            ord_reg    <= '0;
            ocount_reg <= '0;
        end else begin
            if (p2_v_reg) begin
                owr_reg <= owr_reg + 1'b1;
            end
            if (opop) begin
                ord_reg <= ord_reg + 1'b1;
            end
            ocount_reg <= ocount_reg + tep_pkg::OCW'(p2_v_reg) - tep_pkg::OCW'(opop);
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_v_reg) begin
            ofifo_reg[owr_reg] <= res;
        end
    end

    assign m_valid  = ocount_reg != '0;
    assign m_result = ofifo_reg[ord_reg];

    // result queue never overflows thanks to issue credit
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_v_reg |-> (ocount_reg < tep_pkg::OCW'(tep_pkg::O_DEPTH)) || opop)
        else $error("result queue overflow");

    // a queued bundle always holds a job still to issue
    a_head_has_job: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> (avail != '0))
        else $error("empty bundle at queue head");

    // issuing the final job of an item releases its bundle
    a_last_pops: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && job.last) |-> q_pop)
        else $error("last job issued without pop");

    // pipeline stages advance in lockstep
    a_pipe_step: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_v_reg |-> $past(p1_v_reg))
        else $error("pipeline stage skipped");

endmodule

// File: rtl/thermal_erosion_pass_core.sv
// top level of the thermal erosion pass: configuration registers and stream ports
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata[23:0] height_in
//  m_        out  m_tvalid/m_tready  m_tdata: new_height, column, row_index; tlast, tuser
//  cfg_      in   cfg_wr_en          cfg_addr register index, cfg_wdata value
//
// one sample per cycle is accepted while the queue has room; results leave at one per
// cycle while m_tready is high, so on the last row (up to three results per sample)
// the input stalls for the output; a result waits for its lower neighbour to be accepted
// the line stores hold no reset; no clearing pass, a sample is usable right after reset
// reset clears counters, previous samples and all queues; geometry writes restart the window
// either side may stall freely; a short queue splits the front end from the arithmetic
module thermal_erosion_pass_core #(
    parameter int MAX_WIDTH = tep_pkg::MAX_WIDTH_DEF,
    parameter int MAX_ROWS  = tep_pkg::MAX_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // height_in [23:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [47:0]                       m_tdata,   // new_height, column, row_index, pad
    output logic                              m_tlast,   // last request of this input
    output logic                              m_tuser,   // end_of_frame
    input  logic                              cfg_wr_en,
    input  logic [tep_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [tep_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [tep_pkg::GW_W-1:0]    gw_reg;
    logic [tep_pkg::GH_W-1:0]    gh_reg;
    logic [tep_pkg::TALUS_W-1:0] talus_reg;
    logic [tep_pkg::RATE_W-1:0]  rate_reg, rate_in;

    tep_pkg::geom_t      geom;
    tep_pkg::erode_cfg_t ecfg;
    tep_pkg::bundle_t    q_din, q_dout;
    tep_pkg::result_t    result;
    logic                q_push, q_pop, q_valid;
    logic [tep_pkg::QCW-1:0] q_count;

    // rate above one half is clipped at write time
    assign rate_in = (cfg_wdata[15:0] > tep_pkg::RATE_MAX) ? tep_pkg::RATE_MAX
                                                           : cfg_wdata[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gw_reg    <= tep_pkg::GW_W'(256);
            gh_reg    <= tep_pkg::GH_W'(256);
            talus_reg <= '0;
            rate_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                tep_pkg::REG_GRID_WIDTH:  gw_reg    <= cfg_wdata[tep_pkg::GW_W-1:0];
                tep_pkg::REG_GRID_HEIGHT: gh_reg    <= cfg_wdata[tep_pkg::GH_W-1:0];
                tep_pkg::REG_TALUS:       talus_reg <= cfg_wdata[tep_pkg::TALUS_W-1:0];
                tep_pkg::REG_SLIDE_RATE:  rate_reg  <= rate_in;
                default: ;  // unknown index ignored
            endcase
        end
    end

    // geometry write restarts the window at the next edge
    assign geom.grid_width  = gw_reg;
    assign geom.grid_height = gh_reg;
    assign geom.restart     = cfg_wr_en && (cfg_addr == tep_pkg::REG_GRID_WIDTH ||
                                            cfg_addr == tep_pkg::REG_GRID_HEIGHT);
    assign ecfg.talus = talus_reg;
    assign ecfg.rate  = rate_reg;

    tep_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .geom      (geom),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .height_in (s_tdata),
        .q_count   (q_count),
        .push      (q_push),
        .bundle    (q_din)
    );

    tep_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (q_din),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_valid),
        .count     (q_count)
    );

    tep_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (ecfg),
        .q_dout   (q_dout),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // column at [31:24], row_index at [43:32]
    assign m_tdata = {4'b0000, result.row, result.col, result.new_height};
    assign m_tlast = result.last;
    assign m_tuser = result.eof;

endmodule
